// ===== rtl/lpt_pkg.sv =====
// Shared types, constants and saturation helpers of the laser plane triangulation core.
package lpt_pkg;

	localparam int DIV_W = 64;
	localparam int QUO_W = 32;
	localparam int OUT_W = 32;
	localparam int MUL_W = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SQ_W = 64;
	localparam int SUM_W = SQ_W + 2;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam int CTR_W = 28;

	typedef enum logic [CFG_AW-1:0] {
		REG_PLANE_A  = 3'd0,
		REG_PLANE_B  = 3'd1,
		REG_PLANE_C  = 3'd2,
		REG_PLANE_D  = 3'd3,
		REG_FOCAL_X  = 3'd4,
		REG_FOCAL_Y  = 3'd5,
		REG_CENTER_X = 3'd6,
		REG_CENTER_Y = 3'd7
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_N_GO, ST_N_WT, ST_M_GO, ST_M_WT, ST_MUL_A, ST_MUL_B, ST_DEN,
		ST_Z_GO, ST_Z_WT, ST_MUL_X, ST_MUL_Y, ST_CAP_Y, ST_SQ_X, ST_SQ_Y, ST_SQ_Z,
		ST_SQ_E, ST_R_GO, ST_R_WT, ST_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic signed [OUT_W-1:0] sat_s64(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < 64'shFFFF_FFFF_8000_0000)
			return 32'sh8000_0000;
		return 32'(v);
	endfunction

	function automatic logic signed [OUT_W-1:0] quo_to_s32(input logic [QUO_W-1:0] q,
		input logic ovf, input logic neg);
		if (neg) begin
			if (ovf || q > 32'h8000_0000)
				return 32'sh8000_0000;
			return $signed(32'(-q));
		end
		if (ovf || q[31])
			return 32'sh7FFF_FFFF;
		return $signed(q);
	endfunction

endpackage

// ===== rtl/lpt_if.sv =====
// Stream interfaces for pixel requests and reconstructed point requests.
interface lpt_pix_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_col;
	logic [COORD_BITS-1:0] pixel_row;
	logic                  start_over;

	modport source(output valid, pixel_col, pixel_row, start_over, input ready);
	modport sink(input valid, pixel_col, pixel_row, start_over, output ready);
endinterface

interface lpt_pt_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [31:0]        pair_distance;
	logic               distance_valid;
	logic               plane_parallel;

	modport source(output valid, point_x, point_y, point_z, pair_distance,
		distance_valid, plane_parallel, input ready);
	modport sink(input valid, point_x, point_y, point_z, pair_distance,
		distance_valid, plane_parallel, output ready);
endinterface

// ===== rtl/lpt_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, with quotient overflow flag.
module lpt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lpt_pkg::DIV_W-1:0]     dividend,
	input  logic [lpt_pkg::DIV_W-1:0]     divisor,
	output logic [lpt_pkg::QUO_W-1:0]     quo,
	output logic                          ovf,
	output lpt_pkg::unit_stat_t           stat
);

	logic [lpt_pkg::DIV_W-1:0] rem_q;
	logic [lpt_pkg::DIV_W-1:0] div_q;
	logic [lpt_pkg::QUO_W-1:0] low_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic                      ovf_q;
	logic [lpt_pkg::DIV_W:0]   trial;
	logic                      fits;

	assign trial = {rem_q, low_q[lpt_pkg::QUO_W-1]};
	assign fits = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {32'd0, dividend[63:32]};
			low_q <= dividend[31:0];
			div_q <= divisor;
			ovf_q <= {32'd0, dividend[63:32]} >= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 64'(trial - {1'b0, div_q}) : 64'(trial);
			low_q <= {low_q[lpt_pkg::QUO_W-2:0], fits};
		end
	end

	assign quo = low_q;
	assign ovf = ovf_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/lpt_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module lpt_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lpt_pkg::SQ_W-1:0] radicand,
	output logic [31:0]              root,
	output lpt_pkg::unit_stat_t      stat
);

	logic [lpt_pkg::SQ_W-1:0] rad_q;
	logic [lpt_pkg::SQ_W-1:0] res_q;
	logic [lpt_pkg::SQ_W-1:0] bit_q;
	logic [lpt_pkg::SQ_W-1:0] trial;
	logic                     busy_q;
	logic                     done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (rad_q >= trial) begin
				rad_q <= rad_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[31:0];
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/lpt_mul.sv =====
// Shared signed multiplier with a registered product.
module lpt_mul (
	input  logic                               clk,
	input  logic signed [lpt_pkg::MUL_W-1:0]   a,
	input  logic signed [lpt_pkg::MUL_W-1:0]   b,
	output logic signed [lpt_pkg::PROD_W-1:0]  prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

// ===== rtl/laser_plane_point_triangulation_core.sv =====
// Top level: laser plane triangulation sequencer around a shared divider, multiplier and root.
//
// Channel   Role   Carries
// pixel     sink   pixel_col, pixel_row, start_over
// point     source point_x, point_y, point_z, pair_distance, distance_valid, plane_parallel
// cfg_*     write  register index and data, no read-back
//
// A pixel takes two passes of the divider, a third unless its ray is parallel to the plane,
// and one pass of the root unit when it closes a pair whose squared distance fits in 64 bits.
// Its point request is then held until ready is seen.
// Reset clears the sequencer, the pairing flag and the registers to their defaults.
// The block takes no pixel from acceptance until its point request has been taken.
module laser_plane_point_triangulation_core #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lpt_pkg::CFG_AW-1:0]   cfg_idx,
	input  logic [lpt_pkg::CFG_DW-1:0]   cfg_data,
	lpt_pix_if.sink                      pixel,
	lpt_pt_if.source                     point
);

	localparam int DEN_W = 66 - FRAC_BITS;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	logic signed [31:0]            plane_a_q, plane_b_q, plane_c_q, plane_d_q;
	logic [31:0]                   focal_x_q, focal_y_q;
	logic [lpt_pkg::CTR_W-1:0]     center_x_q, center_y_q;

	lpt_pkg::state_t               state_q, state_d;
	logic [COORD_BITS-1:0]         u_q, v_q;
	logic signed [31:0]            n_q, m_q, z_q, x_q, y_q;
	logic signed [DEN_W-1:0]       den_q;
	logic [lpt_pkg::SUM_W-1:0]     sum_q;
	logic [31:0]                   dist_q;
	logic                          dv_q, par_q, have_first_q;
	logic signed [31:0]            held_x_q, held_y_q, held_z_q;

	logic                          div_start, sqrt_start;
	logic [lpt_pkg::DIV_W-1:0]     div_num, div_den;
	logic                          div_neg;
	logic [lpt_pkg::QUO_W-1:0]     div_quo;
	logic                          div_ovf;
	lpt_pkg::unit_stat_t           div_stat, sqrt_stat;
	logic [31:0]                   sqrt_root;
	logic signed [lpt_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [lpt_pkg::PROD_W-1:0] prod_s1;

	logic [31:0]                   fx_eff, fy_eff;
	logic signed [63:0]            num_n, num_m, num_z, den64, prod_fl, den_next64;
	logic signed [DEN_W-1:0]       den_next;
	logic signed [lpt_pkg::QUO_W-1:0] quo_s;
	logic signed [31:0]            y_next;

	assign fx_eff = (focal_x_q == 32'd0) ? 32'd1 : focal_x_q;
	assign fy_eff = (focal_y_q == 32'd0) ? 32'd1 : focal_y_q;
	assign num_n = $signed(64'(u_q) << FRAC_BITS) - $signed(64'(center_x_q));
	assign num_m = $signed(64'(center_y_q)) - $signed(64'(v_q) << FRAC_BITS);
	assign num_z = -(64'(plane_d_q));
	assign den64 = 64'(den_q);
	assign prod_fl = 64'(prod_s1 >>> FRAC_BITS);
	assign den_next64 = den64 + prod_fl;
	assign den_next = DEN_W'(den_next64);
	assign quo_s = lpt_pkg::quo_to_s32(div_quo, div_ovf, div_neg);
	assign y_next = lpt_pkg::sat_s64(prod_fl);

	lpt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .quo(div_quo), .ovf(div_ovf), .stat(div_stat)
	);

	lpt_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand(sum_q[63:0]),
		.root(sqrt_root), .stat(sqrt_stat)
	);

	lpt_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_s1(prod_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_a_q <= '0;
			plane_b_q <= '0;
			plane_c_q <= 32'sd65536;
			plane_d_q <= '0;
			focal_x_q <= 32'd65536;
			focal_y_q <= 32'd65536;
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_we) begin
			unique case (lpt_pkg::cfg_reg_t'(cfg_idx))
				lpt_pkg::REG_PLANE_A: plane_a_q <= $signed(cfg_data);
				lpt_pkg::REG_PLANE_B: plane_b_q <= $signed(cfg_data);
				lpt_pkg::REG_PLANE_C: plane_c_q <= $signed(cfg_data);
				lpt_pkg::REG_PLANE_D: plane_d_q <= $signed(cfg_data);
				lpt_pkg::REG_FOCAL_X: focal_x_q <= cfg_data;
				lpt_pkg::REG_FOCAL_Y: focal_y_q <= cfg_data;
				lpt_pkg::REG_CENTER_X: center_x_q <= cfg_data[lpt_pkg::CTR_W-1:0];
				lpt_pkg::REG_CENTER_Y: center_y_q <= cfg_data[lpt_pkg::CTR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		sqrt_start = 1'b0;
		div_num = '0;
		div_den = 64'd1;
		div_neg = 1'b0;
		mul_a = '0;
		mul_b = '0;
		pixel.ready = 1'b0;
		point.valid = 1'b0;
		unique case (state_q)
			lpt_pkg::ST_IDLE: begin
				pixel.ready = 1'b1;
				if (pixel.valid) state_d = lpt_pkg::ST_N_GO;
			end
			lpt_pkg::ST_N_GO, lpt_pkg::ST_N_WT: begin
				div_num = mag64(num_n) << FRAC_BITS;
				div_den = 64'(fx_eff);
				div_neg = num_n[63];
				div_start = (state_q == lpt_pkg::ST_N_GO);
				if (state_q == lpt_pkg::ST_N_GO) state_d = lpt_pkg::ST_N_WT;
				else if (div_stat.done) state_d = lpt_pkg::ST_M_GO;
			end
			lpt_pkg::ST_M_GO, lpt_pkg::ST_M_WT: begin
				div_num = mag64(num_m) << FRAC_BITS;
				div_den = 64'(fy_eff);
				div_neg = num_m[63];
				div_start = (state_q == lpt_pkg::ST_M_GO);
				if (state_q == lpt_pkg::ST_M_GO) state_d = lpt_pkg::ST_M_WT;
				else if (div_stat.done) state_d = lpt_pkg::ST_MUL_A;
			end
			lpt_pkg::ST_MUL_A: begin
				mul_a = 34'(plane_a_q);
				mul_b = 34'(n_q);
				state_d = lpt_pkg::ST_MUL_B;
			end
			lpt_pkg::ST_MUL_B: begin
				mul_a = 34'(plane_b_q);
				mul_b = 34'(m_q);
				state_d = lpt_pkg::ST_DEN;
			end
			lpt_pkg::ST_DEN: begin
				state_d = (den_next == '0) ? lpt_pkg::ST_OUT : lpt_pkg::ST_Z_GO;
			end
			lpt_pkg::ST_Z_GO, lpt_pkg::ST_Z_WT: begin
				div_num = mag64(num_z) << FRAC_BITS;
				div_den = mag64(den64);
				div_neg = num_z[63] ^ den64[63];
				div_start = (state_q == lpt_pkg::ST_Z_GO);
				if (state_q == lpt_pkg::ST_Z_GO) state_d = lpt_pkg::ST_Z_WT;
				else if (div_stat.done) state_d = lpt_pkg::ST_MUL_X;
			end
			lpt_pkg::ST_MUL_X: begin
				mul_a = 34'(n_q);
				mul_b = 34'(z_q);
				state_d = lpt_pkg::ST_MUL_Y;
			end
			lpt_pkg::ST_MUL_Y: begin
				mul_a = 34'(m_q);
				mul_b = 34'(z_q);
				state_d = lpt_pkg::ST_CAP_Y;
			end
			lpt_pkg::ST_CAP_Y: begin
				state_d = have_first_q ? lpt_pkg::ST_SQ_X : lpt_pkg::ST_OUT;
			end
			lpt_pkg::ST_SQ_X: begin
				mul_a = 34'(x_q) - 34'(held_x_q);
				mul_b = mul_a;
				state_d = lpt_pkg::ST_SQ_Y;
			end
			lpt_pkg::ST_SQ_Y: begin
				mul_a = 34'(y_q) - 34'(held_y_q);
				mul_b = mul_a;
				state_d = lpt_pkg::ST_SQ_Z;
			end
			lpt_pkg::ST_SQ_Z: begin
				mul_a = 34'(z_q) - 34'(held_z_q);
				mul_b = mul_a;
				state_d = lpt_pkg::ST_SQ_E;
			end
			lpt_pkg::ST_SQ_E: begin
				state_d = lpt_pkg::ST_R_GO;
			end
			lpt_pkg::ST_R_GO: begin
				if (sum_q[lpt_pkg::SUM_W-1:lpt_pkg::SQ_W] != 2'd0) begin
					state_d = lpt_pkg::ST_OUT;
				end else begin
					sqrt_start = 1'b1;
					state_d = lpt_pkg::ST_R_WT;
				end
			end
			lpt_pkg::ST_R_WT: begin
				if (sqrt_stat.done) state_d = lpt_pkg::ST_OUT;
			end
			lpt_pkg::ST_OUT: begin
				point.valid = 1'b1;
				if (point.ready) state_d = lpt_pkg::ST_IDLE;
			end
			default: state_d = lpt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
		end else if (state_q == lpt_pkg::ST_IDLE && pixel.valid && pixel.start_over) begin
			have_first_q <= 1'b0;
		end else if (state_q == lpt_pkg::ST_CAP_Y) begin
			have_first_q <= !have_first_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lpt_pkg::ST_IDLE: begin
				u_q <= COORD_BITS'(pixel.pixel_col);
				v_q <= COORD_BITS'(pixel.pixel_row);
				x_q <= '0;
				y_q <= '0;
				z_q <= '0;
				dist_q <= '0;
				dv_q <= 1'b0;
				par_q <= 1'b0;
			end
			lpt_pkg::ST_N_WT: if (div_stat.done) n_q <= quo_s;
			lpt_pkg::ST_M_WT: if (div_stat.done) m_q <= quo_s;
			lpt_pkg::ST_MUL_B: den_q <= DEN_W'(prod_fl + 64'(plane_c_q));
			lpt_pkg::ST_DEN: begin
				den_q <= den_next;
				par_q <= (den_next == '0);
			end
			lpt_pkg::ST_Z_WT: if (div_stat.done) z_q <= quo_s;
			lpt_pkg::ST_CAP_Y: begin
				y_q <= y_next;
			end
			lpt_pkg::ST_MUL_Y: x_q <= lpt_pkg::sat_s64(prod_fl);
			lpt_pkg::ST_SQ_Y: sum_q <= lpt_pkg::SUM_W'(prod_s1[63:0]);
			lpt_pkg::ST_SQ_Z, lpt_pkg::ST_SQ_E:
				sum_q <= sum_q + lpt_pkg::SUM_W'(prod_s1[63:0]);
			lpt_pkg::ST_R_GO: begin
				dv_q <= 1'b1;
				dist_q <= 32'hFFFF_FFFF;
			end
			lpt_pkg::ST_R_WT: if (sqrt_stat.done) dist_q <= sqrt_root;
			default: ;
		endcase
		if (state_q == lpt_pkg::ST_CAP_Y && !have_first_q) begin
			held_x_q <= x_q;
			held_y_q <= y_next;
			held_z_q <= z_q;
		end
	end

	assign point.point_x = x_q;
	assign point.point_y = y_q;
	assign point.point_z = z_q;
	assign point.pair_distance = dist_q;
	assign point.distance_valid = dv_q;
	assign point.plane_parallel = par_q;

	a_parallel_clean: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.plane_parallel |->
			!point.distance_valid && point.point_z == 32'sd0 && point.pair_distance == 32'd0)
		else $error("parallel ray result carries a point");

	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_pair_closed: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.ready && point.distance_valid |-> !have_first_q)
		else $error("pair still held after distance result");

	a_ready_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.ready |-> !div_stat.busy && !sqrt_stat.busy)
		else $error("pixel accepted while a shared unit is busy");

endmodule
